/* hw/rtl/hzr_pkg.sv */
// shared types, codes and helpers for the hallway zigzag retrace driver
package hzr_pkg;

    // default number of movement stack entries
    localparam int STACK_DEPTH_DEF = 64;

    // controller modes
    localparam logic [1:0] MODE_INIT  = 2'd0;
    localparam logic [1:0] MODE_TRACK = 2'd1;
    localparam logic [1:0] MODE_BACK  = 2'd2;

    // event kinds
    localparam logic [1:0] EV_TICK     = 2'd0;
    localparam logic [1:0] EV_START    = 2'd1;
    localparam logic [1:0] EV_STOP     = 2'd2;
    localparam logic [1:0] EV_SET_MODE = 2'd3;

    // config register indexes
    localparam int PADDR_W = 5;
    localparam logic [2:0] REG_SPEED_INITIAL = 3'd0;
    localparam logic [2:0] REG_SPEED_FOLLOW  = 3'd1;
    localparam logic [2:0] REG_SPEED_BACK    = 3'd2;
    localparam logic [2:0] REG_TURN_STRENGTH = 3'd3;
    localparam logic [2:0] REG_ZIGZAG_TARGET = 3'd4;
    localparam logic [2:0] REG_WALL_MARGIN   = 3'd5;

    // register reset values
    localparam logic [8:0]  TURN_STRENGTH_RST = 9'd64;
    localparam logic [13:0] ZIGZAG_TARGET_RST = 14'd1144;
    localparam logic [15:0] WALL_MARGIN_RST   = 16'd300;

    // fixed point limits
    localparam logic [9:0] ONE_Q8    = 10'd256;
    localparam logic [8:0] SPEED_MAX = 9'd500;
    localparam logic [8:0] TURN_MAX  = 9'd256;

    // one movement stack entry
    typedef struct packed {
        logic [9:0]         left;
        logic [9:0]         right;
        logic signed [31:0] travel;
    } hzr_entry_t;

    // raw input item
    typedef struct packed {
        logic [1:0]         mode;
        logic [1:0]         new_mode;
        logic [15:0]        hall_width;
        logic signed [15:0] hall_position;
        logic signed [15:0] hall_heading;
        logic signed [15:0] distance_delta;
        logic signed [15:0] robot_angle;
    } hzr_item_t;

    // event with its precomputed terms
    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         req;
        logic signed [15:0] robot;
        logic signed [31:0] trav_sum;
        logic               turn_go;
        logic signed [15:0] turn_tgt;
        logic               turn_pos;
        logic [9:0]         turn_l;
        logic [9:0]         turn_r;
    } hzr_evt_t;

    // wheel command and status toward the output stage
    typedef struct packed {
        logic       wheels;
        logic [8:0] speed;
        logic [9:0] fl;
        logic [9:0] fr;
        logic       neg;
        logic       run;
        logic [1:0] mode;
        logic       turn;
        logic       drop;
        logic [6:0] entries;
    } hzr_cmd_t;

    // saturate a 33 bit sum to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31])
        begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // saturate a 17 bit sum to signed 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        logic signed [15:0] r;
        if (v[16] != v[15])
        begin
            r = v[16] ? 16'sh8000 : 16'sh7FFF;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    // clamp a 9 bit register value
    function automatic logic [8:0] clamp9(input logic [8:0] v, input logic [8:0] hi);
        return (v > hi) ? hi : v;
    endfunction

endpackage

/* hw/rtl/hzr_if.sv */
// valid/ready channel interfaces for event items and result items
interface hzr_in_if import hzr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [1:0]         new_mode;
    logic [15:0]        hall_width;
    logic signed [15:0] hall_position;
    logic signed [15:0] hall_heading;
    logic signed [15:0] distance_delta;
    logic signed [15:0] robot_angle;

    modport source (
        output valid, mode, new_mode, hall_width, hall_position, hall_heading,
               distance_delta, robot_angle,
        input  ready
    );

    modport sink (
        input  valid, mode, new_mode, hall_width, hall_position, hall_heading,
               distance_delta, robot_angle,
        output ready
    );
endinterface

interface hzr_out_if import hzr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               wheels_set;
    logic signed [10:0] wheel_left;
    logic signed [10:0] wheel_right;
    logic               is_running;
    logic [1:0]         mode_now;
    logic               is_turning;
    logic               stack_full;
    logic [6:0]         stack_entries;

    modport source (
        output valid, wheels_set, wheel_left, wheel_right, is_running, mode_now,
               is_turning, stack_full, stack_entries,
        input  ready
    );

    modport sink (
        input  valid, wheels_set, wheel_left, wheel_right, is_running, mode_now,
               is_turning, stack_full, stack_entries,
        output ready
    );
endinterface

/* hw/rtl/hzr_wheel_out.sv */
// wheel command scaling stage and output register
module hzr_wheel_out import hzr_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  hzr_cmd_t  cmd,
    output logic      cmd_ready,
    hzr_out_if.source out_ch
);

    logic               s3_valid_reg;
    hzr_cmd_t           cmd_reg;
    logic               out_valid_reg;
    hzr_cmd_t           out_cmd_reg;
    logic signed [10:0] wheel_left_reg;
    logic signed [10:0] wheel_right_reg;

    logic               s3_move;
    logic [18:0]        prod_l;
    logic [18:0]        prod_r;
    logic [10:0]        mag_l;
    logic [10:0]        mag_r;
    logic signed [10:0] wl;
    logic signed [10:0] wr;

    // stage handshake
    assign s3_move   = s3_valid_reg && (!out_valid_reg || out_ch.ready);
    assign cmd_ready = !s3_valid_reg || s3_move;

    // speed times factor, shifted down by 8, sign applied
    always_comb
    begin
        prod_l = {10'd0, cmd_reg.speed} * {9'd0, cmd_reg.fl};
        prod_r = {10'd0, cmd_reg.speed} * {9'd0, cmd_reg.fr};
        mag_l  = prod_l[18:8];
        mag_r  = prod_r[18:8];
        wl     = cmd_reg.neg ? -$signed(mag_l) : $signed(mag_l);
        wr     = cmd_reg.neg ? -$signed(mag_r) : $signed(mag_r);
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_ready)
            begin
                s3_valid_reg <= cmd_valid;
            end
            if (s3_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_ready && cmd_valid)
        begin
            cmd_reg <= cmd;
        end
        if (s3_move)
        begin
            out_cmd_reg     <= cmd_reg;
            wheel_left_reg  <= wl;
            wheel_right_reg <= wr;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.wheels_set    = out_cmd_reg.wheels;
    assign out_ch.wheel_left    = wheel_left_reg;
    assign out_ch.wheel_right   = wheel_right_reg;
    assign out_ch.is_running    = out_cmd_reg.run;
    assign out_ch.mode_now      = out_cmd_reg.mode;
    assign out_ch.is_turning    = out_cmd_reg.turn;
    assign out_ch.stack_full    = out_cmd_reg.drop;
    assign out_ch.stack_entries = out_cmd_reg.entries;

endmodule

/* hw/rtl/hallway_zigzag_retrace_driver_top.sv */
// top level: event pipeline, movement stack memory and apb config registers
//
// channel  side  handshake        carries
// in_ch    in    valid/ready      mode, new_mode, hall_width, hall_position, hall_heading,
//                                 distance_delta, robot_angle
// out_ch   out   valid/ready      wheels_set, wheel_left, wheel_right, is_running, mode_now,
//                                 is_turning, stack_full, stack_entries
// apb      in    psel/penable     six config registers at byte address 4*i
//
// a new item is taken while s1 or s2 is empty; the stack entry below the cached top is read
// while the item sits in s1, and state plus the stack write-back are committed as it leaves s2.
// an item then passes the wheel stage register and the output register on its way to out_ch.
// reset clears control state; the stack memory is not cleared, only entries below the
// fill count are ever used.
// a stalled out_ch holds its item; once the wheel stage is full the event stage waits,
// then in_ch drops ready.
module hallway_zigzag_retrace_driver_top import hzr_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    hzr_in_if.sink             in_ch,
    hzr_out_if.source          out_ch
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    // config registers
    logic [8:0]  speed_initial_reg;
    logic [8:0]  speed_follow_reg;
    logic [8:0]  speed_back_reg;
    logic [8:0]  turn_strength_reg;
    logic [13:0] zigzag_target_reg;
    logic [15:0] wall_margin_reg;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    // pipeline
    logic      s1_valid_reg;
    hzr_item_t item_reg;
    logic      s2_valid_reg;
    hzr_evt_t  evt_reg;
    hzr_evt_t  evt_pre;
    logic      in_acc;
    logic      s1_adv;
    logic      s2_commit;

    // controller state
    logic [1:0]         mode_reg;
    logic               run_reg;
    logic               turn_reg;
    logic               tpos_reg;
    logic signed [15:0] tgt_reg;
    logic signed [31:0] trav_reg;
    logic [DW-1:0]      depth_reg;
    logic [9:0]         tl_reg;
    logic [9:0]         tr_reg;
    logic signed [31:0] td_reg;

    logic [1:0]         mode_next;
    logic               run_next;
    logic               turn_next;
    logic               tpos_next;
    logic signed [15:0] tgt_next;
    logic signed [31:0] trav_next;
    logic [DW-1:0]      depth_next;
    logic [9:0]         tl_next;
    logic [9:0]         tr_next;
    logic signed [31:0] td_next;

    // stack memory
    hzr_entry_t    stack_mem [STACK_DEPTH];
    hzr_entry_t    rd_reg;
    logic [DW-1:0] rd_sub;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [DW-1:0] wr_sub;
    logic [AW-1:0] wr_addr;
    hzr_entry_t    wr_data;

    hzr_cmd_t cmd;
    logic     cmd_ready;

    // apb access
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_initial_reg <= '0;
            speed_follow_reg  <= '0;
            speed_back_reg    <= '0;
            turn_strength_reg <= TURN_STRENGTH_RST;
            zigzag_target_reg <= ZIGZAG_TARGET_RST;
            wall_margin_reg   <= WALL_MARGIN_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_SPEED_INITIAL: speed_initial_reg <= pwdata[8:0];
                REG_SPEED_FOLLOW:  speed_follow_reg  <= pwdata[8:0];
                REG_SPEED_BACK:    speed_back_reg    <= pwdata[8:0];
                REG_TURN_STRENGTH: turn_strength_reg <= pwdata[8:0];
                REG_ZIGZAG_TARGET: zigzag_target_reg <= pwdata[13:0];
                REG_WALL_MARGIN:   wall_margin_reg   <= pwdata[15:0];
                default:           ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (cfg_idx)
            REG_SPEED_INITIAL: prdata = {23'd0, speed_initial_reg};
            REG_SPEED_FOLLOW:  prdata = {23'd0, speed_follow_reg};
            REG_SPEED_BACK:    prdata = {23'd0, speed_back_reg};
            REG_TURN_STRENGTH: prdata = {23'd0, turn_strength_reg};
            REG_ZIGZAG_TARGET: prdata = {18'd0, zigzag_target_reg};
            REG_WALL_MARGIN:   prdata = {16'd0, wall_margin_reg};
            default:           prdata = '0;
        endcase
    end

    // stage control: an item leaves s1 only when s2 is empty, so its read sees committed state
    assign in_ch.ready = !s1_valid_reg || !s2_valid_reg;
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign s1_adv      = s1_valid_reg && !s2_valid_reg;
    assign s2_commit   = s2_valid_reg && cmd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_commit)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            item_reg.mode           <= in_ch.mode;
            item_reg.new_mode       <= in_ch.new_mode;
            item_reg.hall_width     <= in_ch.hall_width;
            item_reg.hall_position  <= in_ch.hall_position;
            item_reg.hall_heading   <= in_ch.hall_heading;
            item_reg.distance_delta <= in_ch.distance_delta;
            item_reg.robot_angle    <= in_ch.robot_angle;
        end
        if (s1_adv)
        begin
            evt_reg <= evt_pre;
        end
    end

    // s1: terms that depend on the item, config and the odometry total only
    always_comb
    begin
        logic signed [16:0] head17;
        logic signed [16:0] robot17;
        logic signed [16:0] rel;
        logic signed [16:0] zt;
        logic signed [15:0] t_pos;
        logic signed [15:0] t_neg;
        logic signed [15:0] tgt;
        logic signed [16:0] diff;
        logic signed [18:0] wid;
        logic signed [18:0] pos2;
        logic signed [18:0] left2;
        logic signed [18:0] right2;
        logic signed [18:0] lim;
        logic               near_dir;
        logic [8:0]         ts;
        logic [9:0]         f_lo;
        logic [9:0]         f_hi;

        head17   = $signed({item_reg.hall_heading[15], item_reg.hall_heading});
        robot17  = $signed({item_reg.robot_angle[15], item_reg.robot_angle});
        rel      = robot17 - head17;
        near_dir = rel > 17'sd0;

        // twice the distance to each wall, in half millimetres
        wid    = $signed({3'b000, item_reg.hall_width});
        pos2   = $signed({{2{item_reg.hall_position[15]}}, item_reg.hall_position, 1'b0});
        left2  = wid - pos2;
        right2 = wid + pos2;
        lim    = $signed({2'b00, wall_margin_reg, 1'b0});

        // turn target and direction
        zt    = $signed({3'b000, zigzag_target_reg});
        t_pos = sat16(head17 + zt);
        t_neg = sat16(head17 - zt);
        tgt   = near_dir ? t_neg : t_pos;
        diff  = $signed({tgt[15], tgt}) - robot17;

        // turn factors
        ts   = clamp9(turn_strength_reg, TURN_MAX);
        f_lo = ONE_Q8 - {1'b0, ts};
        f_hi = ONE_Q8 + {1'b0, ts};

        evt_pre.kind     = item_reg.mode;
        evt_pre.req      = item_reg.new_mode;
        evt_pre.robot    = item_reg.robot_angle;
        evt_pre.trav_sum = sat32($signed({trav_reg[31], trav_reg})
                           + $signed({{17{item_reg.distance_delta[15]}},
                                      item_reg.distance_delta}));
        evt_pre.turn_go  = (item_reg.hall_width != 16'd0)
                           && (near_dir ? (left2 <= lim) : (right2 <= lim));
        evt_pre.turn_tgt = tgt;
        evt_pre.turn_pos = diff > 17'sd0;
        evt_pre.turn_l   = (diff > 17'sd0) ? f_lo : f_hi;
        evt_pre.turn_r   = (diff > 17'sd0) ? f_hi : f_lo;
    end

    // stack memory: read the entry below the top every cycle, write back on commit
    always_comb
    begin
        rd_sub  = depth_reg - DW'(2);
        rd_addr = rd_sub[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we && s2_commit)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        rd_reg <= stack_mem[rd_addr];
    end

    // s2: event decision, stack pop and push
    always_comb
    begin
        logic signed [32:0] sum_a;
        logic signed [32:0] sum_b;
        logic signed [31:0] td_add;
        logic               motion;
        logic               retrace;
        logic               drop;
        logic [9:0]         mot_l;
        logic [9:0]         mot_r;
        logic [8:0]         speed;

        mode_next  = mode_reg;
        run_next   = run_reg;
        turn_next  = turn_reg;
        tpos_next  = tpos_reg;
        tgt_next   = tgt_reg;
        trav_next  = trav_reg;
        depth_next = depth_reg;
        tl_next    = tl_reg;
        tr_next    = tr_reg;
        td_next    = td_reg;
        mem_we     = 1'b0;
        wr_sub     = '0;
        wr_data    = '0;
        motion     = 1'b0;
        retrace    = 1'b0;
        drop       = 1'b0;
        mot_l      = '0;
        mot_r      = '0;
        td_add     = td_reg;

        // top distance plus the old total and plus this tick's total
        sum_a = $signed({td_reg[31], td_reg}) + $signed({trav_reg[31], trav_reg});
        sum_b = $signed({td_reg[31], td_reg})
                + $signed({evt_reg.trav_sum[31], evt_reg.trav_sum});

        unique case (evt_reg.kind)
            EV_TICK:
            begin
                if (run_reg)
                begin
                    trav_next = evt_reg.trav_sum;
                    if (mode_reg == MODE_BACK)
                    begin
                        if (depth_reg == '0)
                        begin
                            retrace = 1'b1;
                        end
                        else if (sum_b <= 33'sd0)
                        begin
                            // segment replayed: pop to the entry below
                            depth_next = depth_reg - DW'(1);
                            tl_next    = rd_reg.left;
                            tr_next    = rd_reg.right;
                            td_next    = rd_reg.travel;
                            retrace    = 1'b1;
                        end
                    end
                    else if (mode_reg == MODE_TRACK)
                    begin
                        if (turn_reg)
                        begin
                            if ((tpos_reg && (evt_reg.robot >= tgt_reg))
                                || (!tpos_reg && (evt_reg.robot <= tgt_reg)))
                            begin
                                motion    = 1'b1;
                                mot_l     = ONE_Q8;
                                mot_r     = ONE_Q8;
                                turn_next = 1'b0;
                            end
                        end
                        else if (evt_reg.turn_go)
                        begin
                            turn_next = 1'b1;
                            tgt_next  = evt_reg.turn_tgt;
                            tpos_next = evt_reg.turn_pos;
                            motion    = 1'b1;
                            mot_l     = evt_reg.turn_l;
                            mot_r     = evt_reg.turn_r;
                        end
                    end
                    td_add = sat32(sum_b);
                end
            end
            EV_START:
            begin
                if (!run_reg)
                begin
                    run_next = 1'b1;
                    if (mode_reg == MODE_BACK)
                    begin
                        retrace = 1'b1;
                    end
                    else
                    begin
                        motion = 1'b1;
                        mot_l  = ONE_Q8;
                        mot_r  = ONE_Q8;
                    end
                end
                td_add = sat32(sum_a);
            end
            EV_STOP:
            begin
                run_next = 1'b0;
                motion   = 1'b1;
            end
            EV_SET_MODE:
            begin
                if ((evt_reg.req <= MODE_BACK) && (evt_reg.req != mode_reg))
                begin
                    // close the current mode
                    if (depth_reg != '0)
                    begin
                        if ((mode_reg == MODE_BACK) && (sum_a <= 33'sd0))
                        begin
                            depth_next = depth_reg - DW'(1);
                            tl_next    = rd_reg.left;
                            tr_next    = rd_reg.right;
                            td_next    = rd_reg.travel;
                        end
                        else
                        begin
                            td_next = sat32(sum_a);
                        end
                    end
                    trav_next = '0;
                    mode_next = evt_reg.req;
                    if (evt_reg.req == MODE_BACK)
                    begin
                        retrace = 1'b1;
                    end
                    else
                    begin
                        motion = 1'b1;
                        mot_l  = ONE_Q8;
                        mot_r  = ONE_Q8;
                    end
                end
                td_add = td_next;
            end
            default: ;
        endcase

        // replay the top entry, or stop when the stack is empty
        if (retrace)
        begin
            motion = 1'b1;
            if (depth_next == '0)
            begin
                run_next = 1'b0;
                mot_l    = '0;
                mot_r    = '0;
            end
            else
            begin
                trav_next = '0;
                mot_l     = tl_next;
                mot_r     = tr_next;
            end
        end

        // record a new forward pair
        if (motion && (mode_next != MODE_BACK) && ((mot_l != '0) || (mot_r != '0)))
        begin
            if ((depth_next == '0) || (tl_next != mot_l) || (tr_next != mot_r))
            begin
                if (depth_next < DW'(STACK_DEPTH))
                begin
                    mem_we         = depth_next != '0;
                    wr_sub         = depth_next - DW'(1);
                    wr_data.left   = tl_next;
                    wr_data.right  = tr_next;
                    wr_data.travel = td_add;
                    tl_next        = mot_l;
                    tr_next        = mot_r;
                    td_next        = '0;
                    depth_next     = depth_next + DW'(1);
                end
                else
                begin
                    drop    = 1'b1;
                    td_next = td_add;
                end
            end
        end

        // speed for the mode in force after the event
        unique case (mode_next)
            MODE_TRACK: speed = clamp9(speed_follow_reg, SPEED_MAX);
            MODE_BACK:  speed = clamp9(speed_back_reg, SPEED_MAX);
            default:    speed = clamp9(speed_initial_reg, SPEED_MAX);
        endcase

        cmd.wheels  = motion;
        cmd.speed   = speed;
        cmd.fl      = mot_l;
        cmd.fr      = mot_r;
        cmd.neg     = mode_next == MODE_BACK;
        cmd.run     = run_next;
        cmd.mode    = mode_next;
        cmd.turn    = turn_next;
        cmd.drop    = drop;
        cmd.entries = 7'(depth_next);
    end

    assign wr_addr = wr_sub[AW-1:0];

    // controller state commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_INIT;
            run_reg   <= 1'b0;
            turn_reg  <= 1'b0;
            tpos_reg  <= 1'b0;
            tgt_reg   <= '0;
            trav_reg  <= '0;
            depth_reg <= '0;
        end
        else if (s2_commit)
        begin
            mode_reg  <= mode_next;
            run_reg   <= run_next;
            turn_reg  <= turn_next;
            tpos_reg  <= tpos_next;
            tgt_reg   <= tgt_next;
            trav_reg  <= trav_next;
            depth_reg <= depth_next;
        end
    end

    // cached top entry, meaningful only while the stack is not empty
    always_ff @(posedge clk)
    begin
        if (s2_commit)
        begin
            tl_reg <= tl_next;
            tr_reg <= tr_next;
            td_reg <= td_next;
        end
    end

    hzr_wheel_out u_wheel_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s2_valid_reg),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .out_ch    (out_ch)
    );

endmodule

/* hw/rtl/hzr_checker.sv */
// port level checks for the hallway zigzag retrace driver, bound to the top level
module hzr_checker import hzr_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               wheels_set,
    input logic signed [10:0] wheel_left,
    input logic signed [10:0] wheel_right,
    input logic [1:0]         mode_now,
    input logic               stack_full,
    input logic [6:0]         stack_entries
);

    logic in_acc;

    assign in_acc = in_valid && in_ready;

    // a held result item keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(wheels_set)
            && $stable(wheel_left) && $stable(wheel_right) && $stable(stack_entries))
        else $error("result item changed while stalled");

    // no three items accepted back to back
    a_rate: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc ##1 in_acc |=> !in_acc)
        else $error("items accepted faster than the stack interlock allows");

    // a dropped push only happens when wheel commands are issued
    a_drop_wheels: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stack_full |-> wheels_set)
        else $error("stack full flag without wheel commands");

    // no wheel command means zero wheels
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !wheels_set |-> wheel_left == 11'sd0 && wheel_right == 11'sd0)
        else $error("wheel values without wheel commands");

    // retracing never drives forward
    a_back_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && wheels_set && mode_now == MODE_BACK
            |-> (wheel_left[10] || wheel_left == 11'sd0)
                && (wheel_right[10] || wheel_right == 11'sd0))
        else $error("forward wheel command while retracing");

endmodule

bind hallway_zigzag_retrace_driver_top hzr_checker u_hzr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .wheels_set    (out_ch.wheels_set),
    .wheel_left    (out_ch.wheel_left),
    .wheel_right   (out_ch.wheel_right),
    .mode_now      (out_ch.mode_now),
    .stack_full    (out_ch.stack_full),
    .stack_entries (out_ch.stack_entries)
);
